/* rtl/annexb_nal_unit_splitter_macros.svh */
// Assertion macros for the Annex B NAL unit splitter.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ANB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ANB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/annexb_pkg.sv */
// Shared types, codes and header classification for the Annex B splitter.
// No dependencies; imported by every module of the block.
package annexb_pkg;

  localparam int UNIT_LIMIT_DEF    = 16;
  localparam int POSITION_BITS_DEF = 24;
  localparam int FIFO_DEPTH        = 4;

  localparam logic [1:0] CODEC_H264 = 2'd0;
  localparam logic [1:0] CODEC_H265 = 2'd1;

  typedef logic [2:0] cls_t;

  localparam cls_t CLS_UNKNOWN = 3'd0;
  localparam cls_t CLS_VPS     = 3'd1;
  localparam cls_t CLS_SPS     = 3'd2;
  localparam cls_t CLS_PPS     = 3'd3;
  localparam cls_t CLS_SEI     = 3'd4;

  localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
  localparam logic [7:0] H265_TYPE_MASK = 8'h7E;
  localparam logic [7:0] SC_ZERO        = 8'h00;
  localparam logic [7:0] SC_ONE         = 8'h01;

  localparam logic [5:0] H264_SEI  = 6'd6;
  localparam logic [5:0] H264_SPS  = 6'd7;
  localparam logic [5:0] H264_PPS  = 6'd8;
  localparam logic [5:0] H265_VPS  = 6'd32;
  localparam logic [5:0] H265_SPS  = 6'd33;
  localparam logic [5:0] H265_PPS  = 6'd34;
  localparam logic [5:0] H265_SEIP = 6'd39;
  localparam logic [5:0] H265_SEIS = 6'd40;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
  } push_t;

  function automatic cls_t classify(input logic [1:0] codec, input logic [7:0] hdr);
    logic [5:0] t;
    cls_t       cls;
    cls = CLS_UNKNOWN;
    if (codec == CODEC_H264) begin
      t = 6'(hdr & H264_TYPE_MASK);
      case (t)
        H264_SPS: cls = CLS_SPS;
        H264_PPS: cls = CLS_PPS;
        H264_SEI: cls = CLS_SEI;
        default:  cls = CLS_UNKNOWN;
      endcase
    end else begin
      t = 6'((hdr & H265_TYPE_MASK) >> 1);
      case (t)
        H265_VPS:  cls = CLS_VPS;
        H265_SPS:  cls = CLS_SPS;
        H265_PPS:  cls = CLS_PPS;
        H265_SEIP: cls = CLS_SEI;
        H265_SEIS: cls = CLS_SEI;
        default:   cls = CLS_UNKNOWN;
      endcase
    end
    return cls;
  endfunction

endpackage

/* rtl/annexb_fifo.sv */
// Result queue: takes up to two records a cycle, returns one a cycle.
// Depends on annexb_pkg for the push request type.
module annexb_fifo #(
  parameter int DEPTH  = 4,
  parameter int DATA_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  annexb_pkg::push_t    push,
  input  logic [DATA_W-1:0]    wr_a_data,
  input  logic [DATA_W-1:0]    wr_b_data,
  input  logic                 rd_en,
  output logic [DATA_W-1:0]    rd_data,
  output logic                 not_empty,
  output logic                 room
);
  import annexb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_b;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;

  assign not_empty = (cnt_r != '0);
  assign room      = (cnt_r <= CW'(DEPTH - 2));
  assign pop       = rd_en && not_empty;
  assign rd_data   = mem_r[rd_ptr_r];
  assign wr_ptr_b  = PW'(wr_ptr_r + PW'(1));

  always_comb begin
    wr_ptr_nxt = PW'(wr_ptr_r + PW'(push.wr_a) + PW'(push.wr_b));
    rd_ptr_nxt = PW'(rd_ptr_r + PW'(pop));
    cnt_nxt    = CW'(cnt_r + CW'(push.wr_a) + CW'(push.wr_b) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.wr_a) begin
      mem_r[wr_ptr_r] <= wr_a_data;
    end
    if (push.wr_b) begin
      mem_r[wr_ptr_b] <= wr_b_data;
    end
  end

endmodule

/* rtl/annexb_scan.sv */
// Start code scanner and unit tracker: one byte per cycle while item_valid is high, up to two records out.
// Depends on annexb_pkg for classification, codes and the push request type.
module annexb_scan #(
  parameter int UNIT_LIMIT    = 16,
  parameter int POSITION_BITS = 24,
  parameter int REC_W         = 15 + 2 * POSITION_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  input  logic              item_valid,
  input  logic [7:0]        item_byte,
  input  logic              item_end,
  output annexb_pkg::push_t push,
  output logic [REC_W-1:0]  rec_a,
  output logic [REC_W-1:0]  rec_b
);
  import annexb_pkg::*;

  localparam int P     = POSITION_BITS;
  localparam int CNT_W = ($clog2(UNIT_LIMIT + 1) > 5) ? $clog2(UNIT_LIMIT + 1) : 5;

  function automatic logic [REC_W-1:0] pack_rec(
    input logic valid, input cls_t cls, input logic [P-1:0] off,
    input logic [P-1:0] size, input logic [CNT_W-1:0] idx,
    input logic [CNT_W-1:0] cnt, input logic trunc, input logic last
  );
    return {last, trunc, cnt[4:0], idx[3:0], size, off, cls, valid};
  endfunction

  logic [1:0]       codec_r;
  logic [23:0]      win_r, win_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic [P-1:0]     pos_r, pos_nxt;
  logic             open_r, open_nxt;
  logic [P-1:0]     off_r, off_nxt;
  logic             len4_r, len4_nxt;
  logic [1:0]       skip_r, skip_nxt;
  cls_t             cls_r, cls_nxt;
  logic [CNT_W-1:0] found_r, found_nxt;
  logic             lim_r, lim_nxt;

  logic             sup, start, sc_len4, drop;
  logic [7:0]       b0, b1, b2;
  logic [P-1:0]     p_sc, endpos, len_old, len_new;
  logic [CNT_W-1:0] newcnt;
  logic [REC_W-1:0] end_rec;

  always_comb begin
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    open_nxt  = open_r;
    off_nxt   = off_r;
    len4_nxt  = len4_r;
    skip_nxt  = skip_r;
    cls_nxt   = cls_r;
    found_nxt = found_r;
    lim_nxt   = lim_r;
    push      = '0;
    rec_a     = '0;
    rec_b     = '0;
    sup       = (codec_r <= CODEC_H265);
    start     = 1'b0;
    b0        = win_r[23:16];
    b1        = win_r[15:8];
    b2        = win_r[7:0];
    sc_len4   = (b2 != SC_ONE);
    p_sc      = P'(pos_r - P'(3));
    endpos    = P'(pos_r + P'(1));
    len_old   = len4_r ? P'(4) : P'(3);
    newcnt    = CNT_W'(found_r + CNT_W'(open_r));
    drop      = (newcnt >= CNT_W'(UNIT_LIMIT));
    len_new   = '0;
    end_rec   = '0;

    if (item_valid) begin
      if (sup) begin
        if (skip_r != 2'd0) begin
          if (skip_r == 2'd3 && open_r && len4_r) begin
            cls_nxt = classify(codec_r, item_byte);
          end
          skip_nxt = skip_r - 2'd1;
        end else if (fill_r == 2'd3) begin
          if (b0 == SC_ZERO && b1 == SC_ZERO &&
              (b2 == SC_ONE || (b2 == SC_ZERO && item_byte == SC_ONE))) begin
            start = 1'b1;
          end
        end
      end else if (skip_r != 2'd0) begin
        skip_nxt = skip_r - 2'd1;
      end

      if (start) begin
        if (drop) begin
          lim_nxt = 1'b1;
        end
        if (open_r) begin
          push.wr_a = 1'b1;
          rec_a     = pack_rec(1'b1, cls_r, off_r, P'(p_sc - off_r - len_old),
                               found_r, newcnt, lim_nxt, 1'b0);
          found_nxt = newcnt;
        end
        skip_nxt = sc_len4 ? 2'd3 : 2'd2;
        if (drop) begin
          open_nxt = 1'b0;
        end else begin
          open_nxt = 1'b1;
          off_nxt  = p_sc;
          len4_nxt = sc_len4;
          cls_nxt  = sc_len4 ? CLS_UNKNOWN : classify(codec_r, item_byte);
        end
      end

      win_nxt  = {win_r[15:0], item_byte};
      fill_nxt = (fill_r == 2'd3) ? 2'd3 : fill_r + 2'd1;
      pos_nxt  = endpos;

      if (item_end) begin
        len_new = len4_nxt ? P'(4) : P'(3);
        if (sup && open_nxt) begin
          end_rec = pack_rec(1'b1, cls_nxt, off_nxt, P'(endpos - off_nxt - len_new),
                             found_nxt, CNT_W'(found_nxt + CNT_W'(1)), lim_nxt, 1'b1);
          if (push.wr_a) begin
            push.wr_b = 1'b1;
            rec_b     = end_rec;
          end else begin
            push.wr_a = 1'b1;
            rec_a     = end_rec;
          end
        end else if (push.wr_a) begin
          rec_a[REC_W-1] = 1'b1;
        end else begin
          push.wr_a = 1'b1;
          rec_a     = pack_rec(1'b0, CLS_UNKNOWN, '0, '0, '0, found_nxt, lim_nxt, 1'b1);
        end
        win_nxt   = '1;
        fill_nxt  = 2'd0;
        pos_nxt   = '0;
        open_nxt  = 1'b0;
        off_nxt   = '0;
        len4_nxt  = 1'b0;
        skip_nxt  = 2'd0;
        cls_nxt   = CLS_UNKNOWN;
        found_nxt = '0;
        lim_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r <= CODEC_H264;
      win_r   <= '1;
      fill_r  <= 2'd0;
      pos_r   <= '0;
      open_r  <= 1'b0;
      off_r   <= '0;
      len4_r  <= 1'b0;
      skip_r  <= 2'd0;
      cls_r   <= CLS_UNKNOWN;
      found_r <= '0;
      lim_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        codec_r <= cfg_wr_data;
      end
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      pos_r   <= pos_nxt;
      open_r  <= open_nxt;
      off_r   <= off_nxt;
      len4_r  <= len4_nxt;
      skip_r  <= skip_nxt;
      cls_r   <= cls_nxt;
      found_r <= found_nxt;
      lim_r   <= lim_nxt;
    end
  end

endmodule

/* rtl/annexb_nal_unit_splitter.sv */
// Top level of the Annex B NAL unit splitter: input register, scanner, result queue.
// Depends on annexb_pkg, annexb_scan, annexb_fifo and the assertion macro header.
//
//   channel  direction  payload
//   in_      slave      tdata: stream_byte; tlast: buffer_end
//   out_     master     tdata: record_valid..truncated; tlast: last
//   cfg_     write      codec_select
//
// At most one byte is taken per cycle, while in_tready is high; an accepted byte is held
// in the input register and scanned once the queue has room. A byte yields zero, one or
// two records; the queue drains one record a cycle while out_tready is high.
// in_tready drops when a byte is held and the four-entry queue cannot hold two more records.
// rst_n clears all scan state and the queue; codec_select returns to H.264.
`include "annexb_nal_unit_splitter_macros.svh"

module annexb_nal_unit_splitter #(
  parameter int UNIT_LIMIT    = annexb_pkg::UNIT_LIMIT_DEF,
  parameter int POSITION_BITS = annexb_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_wr_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] stream_byte
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // record_valid, unit_class, unit_offset, unit_size, unit_index, unit_count,
  // truncated, zero padding
  output logic [((14 + 2 * POSITION_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                          out_tlast
);
  import annexb_pkg::*;

  localparam int REC_W   = 15 + 2 * POSITION_BITS;
  localparam int TDATA_W = ((14 + 2 * POSITION_BITS + 7) / 8) * 8;

  logic              vld_r, vld_nxt;
  logic [7:0]        byte_r;
  logic              end_r;
  logic              room, adv, in_acc;
  push_t             push;
  logic [REC_W-1:0]  rec_a, rec_b, rd_data;

  assign adv       = vld_r && room;
  assign in_tready = !vld_r || room;
  assign in_acc    = in_tvalid && in_tready;
  assign vld_nxt   = in_acc ? 1'b1 : (adv ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata;
      end_r  <= in_tlast;
    end
  end

  annexb_scan #(
    .UNIT_LIMIT    (UNIT_LIMIT),
    .POSITION_BITS (POSITION_BITS),
    .REC_W         (REC_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (adv),
    .item_byte   (byte_r),
    .item_end    (end_r),
    .push        (push),
    .rec_a       (rec_a),
    .rec_b       (rec_b)
  );

  annexb_fifo #(
    .DEPTH  (FIFO_DEPTH),
    .DATA_W (REC_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_a_data (rec_a),
    .wr_b_data (rec_b),
    .rd_en     (out_tready),
    .rd_data   (rd_data),
    .not_empty (out_tvalid),
    .room      (room)
  );

  assign out_tdata = TDATA_W'(rd_data[REC_W-2:0]);
  assign out_tlast = rd_data[REC_W-1];

  `ANB_ASSERT_SAME(a_push_only_on_item, !adv, push == '0, "record pushed with no byte")
  `ANB_ASSERT_SAME(a_second_after_first, push.wr_b, push.wr_a, "second record without first")
  `ANB_ASSERT_SAME(a_end_gives_last, adv && end_r,
    push.wr_a && (push.wr_b ? rec_b[REC_W-1] : rec_a[REC_W-1]), "buffer end without last")
  `ANB_ASSERT_NEXT(a_stall_holds_item, vld_r && !room, vld_r, "stalled byte lost")

endmodule
